// ===== hdl/assert_macros.svh =====
// Assertion macros for the profiler table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/cpp_tbl_pkg.sv =====
// Package: payload types, mode and status codes, controller command and status structs.
package cpp_tbl_pkg;
  localparam int unsigned TableSlots = 2048;
  localparam logic [31:0] FnvMult = 32'd16777619;
  localparam logic [31:0] RootSeed = 32'd16777619;

  localparam logic [1:0] ModeEnter = 2'd0;
  localparam logic [1:0] ModeLeave = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatNoOpen = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] scope_hash;
    logic [15:0] scope_tag;
    logic [63:0] elapsed_time;
    logic [10:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [11:0] entry_index;
    logic [11:0] parent_entry;
    logic        created;
    logic [1:0]  status;
    logic        occupied;
    logic [15:0] tag_out;
    logic [63:0] max_time;
    logic [63:0] total_time;
    logic [63:0] square_sum;
    logic [31:0] hit_count;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic seed_rd;
    logic hash_step;
    logic probe_rd;
    logic probe_adv;
    logic create;
    logic leave_rd;
    logic sq_mul;
    logic leave_wr;
    logic rd_slot;
    logic finish;
    logic [1:0] fin_status;
    logic fin_created;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic cur_open;
    logic hash_done;
    logic probe_hit;
    logic probe_free;
    logic table_full;
    logic leave_ok;
    logic clr_done;
  } dp_stat_t;
endpackage

// ===== hdl/cpp_tbl_datapath.sv =====
// Datapath: slot memories, hash unit, probe pointer, statistics update, result register.
module cpp_tbl_datapath #(
  parameter int unsigned TABLE_SLOTS = cpp_tbl_pkg::TableSlots
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpp_tbl_pkg::in_word_t  in_word_i,
  input  cpp_tbl_pkg::dp_cmd_t   cmd_i,
  output cpp_tbl_pkg::dp_stat_t  stat_o,
  output cpp_tbl_pkg::out_word_t out_word_o
);
  import cpp_tbl_pkg::*;
  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned EW = IW + 1;
  localparam logic [EW-1:0] NoEntry = EW'(TABLE_SLOTS);

  logic [31:0] mem_hash   [TABLE_SLOTS];
  logic [EW-1:0] mem_parent [TABLE_SLOTS];
  logic [15:0] mem_tag    [TABLE_SLOTS];
  logic [63:0] mem_max    [TABLE_SLOTS];
  logic [63:0] mem_sum    [TABLE_SLOTS];
  logic [63:0] mem_sq     [TABLE_SLOTS];
  logic [31:0] mem_hits   [TABLE_SLOTS];
  logic        mem_valid  [TABLE_SLOTS];

  in_word_t    in_q;
  logic [EW-1:0] cur_q, used_q;
  logic [31:0] h_q;
  logic [1:0]  byte_q;
  logic        hash_done_q;
  logic [IW-1:0] addr_q, clr_q;
  logic        clr_done_q;
  logic        rv_q;
  logic [31:0] rhash_q, rhits_q;
  logic [EW-1:0] rpar_q;
  logic [15:0] rtag_q;
  logic [63:0] rmax_q, rsum_q, rsq_q, sq_ll_q;
  logic [31:0] sq_lh_q;
  out_word_t   out_q;

  logic [7:0]  byte_sel;
  logic [31:0] h_d;
  always_comb begin
    case (byte_q)
      2'd0: byte_sel = in_q.scope_hash[31:24];
      2'd1: byte_sel = in_q.scope_hash[23:16];
      2'd2: byte_sel = in_q.scope_hash[15:8];
      default: byte_sel = in_q.scope_hash[7:0];
    endcase
    h_d = (h_q * FnvMult) ^ {24'd0, byte_sel};
  end

  logic [IW-1:0] cur_a;
  assign cur_a = cur_q[IW-1:0];

  logic [EW-1:0] fin_idx;
  always_comb begin
    fin_idx = cur_q;
    if (in_q.mode == ModeRead) fin_idx = {1'b0, in_q.read_index[IW-1:0]};
    else if (in_q.mode == ModeEnter && cmd_i.fin_status == StatOk) fin_idx = {1'b0, addr_q};
  end

  logic [IW-1:0] rd_a;
  assign rd_a = cmd_i.leave_rd ? cur_a : fin_idx[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= NoEntry;
      used_q <= '0;
      clr_q <= '0;
      clr_done_q <= 1'b0;
      hash_done_q <= 1'b0;
      byte_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == IW'(TABLE_SLOTS - 1)) clr_done_q <= 1'b1;
      end
      if (cmd_i.load_in) begin
        byte_q <= '0;
        hash_done_q <= 1'b0;
      end else if (cmd_i.hash_step) begin
        byte_q <= byte_q + 1'b1;
        if (byte_q == 2'd3) hash_done_q <= 1'b1;
      end
      if (cmd_i.create) begin
        used_q <= used_q + 1'b1;
        cur_q <= {1'b0, addr_q};
      end else if (cmd_i.finish && in_q.mode == ModeEnter && cmd_i.fin_status == StatOk) begin
        cur_q <= {1'b0, addr_q};
      end else if (cmd_i.leave_wr) begin
        cur_q <= (rpar_q > NoEntry) ? NoEntry : rpar_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_word_i;
    if (cmd_i.seed_rd) h_q <= cur_q[IW] ? RootSeed : mem_hash[cur_a];
    else if (cmd_i.hash_step) h_q <= h_d;
    if (cmd_i.hash_step && byte_q == 2'd3) addr_q <= h_d[IW-1:0];
    else if (cmd_i.probe_adv) addr_q <= addr_q + 1'b1;
    else if (cmd_i.leave_rd) addr_q <= cur_a;
    else if (cmd_i.rd_slot) addr_q <= in_q.read_index[IW-1:0];
    if (cmd_i.probe_rd || cmd_i.leave_rd || cmd_i.rd_slot) begin
      rv_q <= mem_valid[cmd_i.leave_rd ? cur_a :
                        cmd_i.rd_slot ? in_q.read_index[IW-1:0] : addr_q];
      rhash_q <= mem_hash[cmd_i.leave_rd ? cur_a :
                          cmd_i.rd_slot ? in_q.read_index[IW-1:0] : addr_q];
    end
    if (cmd_i.clr_step) mem_valid[clr_q] <= 1'b0;
    else if (cmd_i.create) mem_valid[addr_q] <= 1'b1;
    if (cmd_i.create) begin
      mem_hash[addr_q] <= h_q;
      mem_parent[addr_q] <= cur_q;
      mem_tag[addr_q] <= in_q.scope_tag;
      mem_max[addr_q] <= '0;
      mem_sum[addr_q] <= '0;
      mem_sq[addr_q] <= '0;
      mem_hits[addr_q] <= '0;
    end else if (cmd_i.leave_wr) begin
      mem_max[addr_q] <= (in_q.elapsed_time > rmax_q) ? in_q.elapsed_time : rmax_q;
      mem_sum[addr_q] <= rsum_q + in_q.elapsed_time;
      mem_sq[addr_q] <= rsq_q + sq_ll_q + {sq_lh_q[30:0], 33'd0};
      mem_hits[addr_q] <= rhits_q + 32'd1;
    end
    if (cmd_i.finish || cmd_i.leave_rd) begin
      rpar_q <= mem_parent[rd_a];
      rtag_q <= mem_tag[rd_a];
      rmax_q <= mem_max[rd_a];
      rsum_q <= mem_sum[rd_a];
      rsq_q <= mem_sq[rd_a];
      rhits_q <= mem_hits[rd_a];
    end
    if (cmd_i.sq_mul) begin
      sq_ll_q <= {32'd0, in_q.elapsed_time[31:0]} * {32'd0, in_q.elapsed_time[31:0]};
      sq_lh_q <= in_q.elapsed_time[31:0] * in_q.elapsed_time[63:32];
    end
  end

  // Report stage: in the cycle after finish, memory read data is in r*_q.
  logic        rep_q, rep_v_q;
  logic [11:0] rep_show_q;
  logic        rep_cr_q;
  logic [1:0]  rep_st_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rep_q <= 1'b0;
    else rep_q <= cmd_i.finish;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rep_v_q <= !fin_idx[IW] && mem_valid[fin_idx[IW-1:0]] &&
                 !(in_q.mode == ModeRead && {1'b0, in_q.read_index} >= 12'(TABLE_SLOTS));
      rep_show_q <= (in_q.mode == ModeRead) ? {1'b0, in_q.read_index} : 12'(fin_idx);
      rep_cr_q <= cmd_i.fin_created;
      rep_st_q <= cmd_i.fin_status;
    end
    if (rep_q) begin
      out_q.entry_index <= rep_show_q;
      out_q.created <= rep_cr_q;
      out_q.status <= rep_st_q;
      out_q.occupied <= rep_v_q;
      out_q.parent_entry <= rep_v_q ? 12'(rpar_q) : 12'(TABLE_SLOTS);
      out_q.tag_out <= rep_v_q ? rtag_q : '0;
      out_q.max_time <= rep_v_q ? rmax_q : '0;
      out_q.total_time <= rep_v_q ? rsum_q : '0;
      out_q.square_sum <= rep_v_q ? rsq_q : '0;
      out_q.hit_count <= rep_v_q ? rhits_q : '0;
    end
  end

  assign out_word_o = out_q;
  assign stat_o.mode = in_q.mode;
  assign stat_o.cur_open = !cur_q[IW];
  assign stat_o.hash_done = hash_done_q;
  assign stat_o.probe_hit = rv_q && rhash_q == h_q;
  assign stat_o.probe_free = !rv_q;
  assign stat_o.table_full = (used_q + 1'b1) >= NoEntry;
  assign stat_o.leave_ok = rv_q;
  assign stat_o.clr_done = clr_done_q;
endmodule

// ===== hdl/cpp_tbl_ctrl.sv =====
// Controller: sequences clear, enter, leave and read operations and the output handshake.
module cpp_tbl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cpp_tbl_pkg::dp_stat_t stat_i,
  output cpp_tbl_pkg::dp_cmd_t  cmd_o
);
  import cpp_tbl_pkg::*;
  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SDisp = 4'd2, SHash = 4'd3,
                         SProbe = 4'd4, SCheck = 4'd5, SLvRd = 4'd6, SLvChk = 4'd7,
                         SLvWr = 4'd8, SFin = 4'd9, SRep = 4'd10, SOut = 4'd11;
  logic [3:0] state_q, state_d;
  logic [1:0] st_q, st_d;
  logic cr_q, cr_d;

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    cr_d = cr_q;
    cmd_o = '0;
    cmd_o.fin_status = st_q;
    cmd_o.fin_created = cr_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          cmd_o.clr_step = 1'b0;
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          st_d = StatOk;
          cr_d = 1'b0;
          state_d = SDisp;
        end
      end
      SDisp: begin
        case (stat_i.mode)
          ModeEnter: begin
            cmd_o.seed_rd = 1'b1;
            state_d = SHash;
          end
          ModeLeave: begin
            if (stat_i.cur_open) begin
              cmd_o.leave_rd = 1'b1;
              cmd_o.sq_mul = 1'b1;
              state_d = SLvChk;
            end else begin
              st_d = StatNoOpen;
              state_d = SFin;
            end
          end
          default: state_d = SFin;
        endcase
      end
      SHash: begin
        cmd_o.hash_step = 1'b1;
        if (stat_i.hash_done) begin
          cmd_o.hash_step = 1'b0;
          cmd_o.probe_rd = 1'b1;
          state_d = SCheck;
        end
      end
      SProbe: begin
        cmd_o.probe_rd = 1'b1;
        state_d = SCheck;
      end
      SCheck: begin
        if (stat_i.probe_hit) state_d = SFin;
        else if (!stat_i.probe_free) begin
          cmd_o.probe_adv = 1'b1;
          state_d = SProbe;
        end else if (stat_i.table_full) begin
          st_d = StatFull;
          state_d = SFin;
        end else begin
          cmd_o.create = 1'b1;
          cr_d = 1'b1;
          state_d = SFin;
        end
      end
      SLvChk: begin
        if (stat_i.leave_ok) state_d = SLvWr;
        else begin
          st_d = StatNoOpen;
          state_d = SFin;
        end
      end
      SLvWr: begin
        cmd_o.leave_wr = 1'b1;
        state_d = SFin;
      end
      SFin: begin
        cmd_o.finish = 1'b1;
        state_d = SRep;
      end
      SRep: state_d = SOut;
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      st_q <= StatOk;
      cr_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      cr_q <= cr_d;
    end
  end
endmodule

// ===== hdl/call_path_profiler_table_top.sv =====
// Top level: call-path profiler table.
//  channel | signals                        | word
//  in      | in_valid_i / in_ready_o        | cpp_tbl_pkg::in_word_t
//  out     | out_valid_o / out_ready_i      | cpp_tbl_pkg::out_word_t
// Each word is sequenced by the controller over the single-port slot memories and the
// serial hash, one byte per cycle; an enter runs extra probes while slots are taken.
// After reset a valid-bit clear runs over every slot with input not ready.
// One word at a time; output stall holds the block.
module call_path_profiler_table_top #(
  parameter int unsigned TABLE_SLOTS = cpp_tbl_pkg::TableSlots
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cpp_tbl_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cpp_tbl_pkg::out_word_t out_word_o
);
  import cpp_tbl_pkg::*;
  `include "assert_macros.svh"
  dp_cmd_t cmd;
  dp_stat_t stat;

  cpp_tbl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );
  cpp_tbl_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk_i, .rst_ni, .in_word_i, .cmd_i(cmd), .stat_o(stat), .out_word_o
  );

  `ASSERT_IMPL(a_no_overlap, in_ready_o, !out_valid_o)
  `ASSERT_IMPL(a_create_ok, cmd.create, !stat.table_full)
  `ASSERT_NEXT(a_out_after, out_valid_o && out_ready_i, in_ready_o)
endmodule
